FILE: rtl/gbb_pkg.sv
`default_nettype none

package gbb_pkg;

  // Input item kinds
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } gbb_cmd_t;

  // Queue between the front and back parts (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int FB_ADDR_W = 13;

  // One classified item as it waits in the queue
  typedef struct packed {
    gbb_cmd_t    kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [8:0]  end_row;
    logic [6:0]  width;
    logic        live;
    logic [7:0]  data;
  } gbb_entry_t;

  // One result beat
  typedef struct packed {
    logic [FB_ADDR_W-1:0] fb_address;
    logic [7:0]           pixel_bits;
    logic                 write_enable;
    logic                 clear_op;
    logic                 clipped;
    logic                 glyph_done;
    logic                 last;
  } gbb_result_t;

endpackage

`default_nettype wire

FILE: rtl/gbb_front.sv
`default_nettype none

module gbb_front import gbb_pkg::*; #(
  parameter int MAX_GLYPH_SIZE = 64
) (
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_start_col,
  input  logic [7:0] in_start_row,
  input  logic [6:0] in_glyph_width,
  input  logic [6:0] in_glyph_height,
  input  logic [7:0] in_data_byte,
  input  logic       q_full,
  output logic       q_push,
  output gbb_entry_t q_entry
);

  // Clamp a size field to the largest glyph allowed
  function automatic logic [6:0] limit_size(input logic [6:0] v);
    logic [6:0] s;
    s = v;
    if ({1'b0, v} > 8'(MAX_GLYPH_SIZE)) s = 7'(MAX_GLYPH_SIZE);
    return s;
  endfunction

  logic [6:0] w_lim;
  logic [6:0] h_lim;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    w_lim = limit_size(in_glyph_width);
    h_lim = limit_size(in_glyph_height);
    q_entry         = '0;
    q_entry.kind    = gbb_cmd_t'(in_command);
    q_entry.col     = in_start_col;
    q_entry.row     = in_start_row;
    q_entry.end_row = {1'b0, in_start_row} + {2'b00, h_lim};
    q_entry.width   = w_lim;
    q_entry.live    = (w_lim != '0) && (h_lim != '0);
    q_entry.data    = in_data_byte;
  end

endmodule

`default_nettype wire

FILE: rtl/gbb_queue.sv
`default_nettype none

module gbb_queue import gbb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  gbb_entry_t push_entry,
  output logic       full,
  output logic       head_valid,
  output gbb_entry_t head,
  input  logic       pop
);

  gbb_entry_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_entry;
  end

endmodule

`default_nettype wire

FILE: rtl/gbb_back.sv
`default_nettype none

module gbb_back import gbb_pkg::*; #(
  parameter int VRAM_ROW_PIXELS = 256,
  parameter int BUF_ROWS        = 208,
  parameter int BUF_ROW_BYTES   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic        cfg_clear_mode,
  input  logic        head_valid,
  input  gbb_entry_t  head,
  output logic        pop,
  input  logic        out_stall,
  output logic        res_valid,
  output gbb_result_t res
);

  localparam int SUM_W = 10 + $clog2(VRAM_ROW_PIXELS);
  localparam int AW    = SUM_W - 3;
  localparam int LIMIT = BUF_ROWS * BUF_ROW_BYTES;

  logic              clear_mode_r;
  logic              active_r, active_nxt;
  logic [8:0]        cursor_col_r, cursor_col_nxt;
  logic [8:0]        cursor_row_r, cursor_row_nxt;
  logic [8:0]        end_row_r, end_row_nxt;
  logic [7:0]        left_col_r, left_col_nxt;
  logic [6:0]        row_width_r, row_width_nxt;
  logic [6:0]        width_left_r, width_left_nxt;
  logic [2:0]        bit_offset_r, bit_offset_nxt;
  logic              out_valid_r, out_valid_nxt;
  gbb_result_t       out_r, out_nxt;

  logic              out_ready;
  logic [2:0]        sub;
  logic [3:0]        room_byte, room_data, use_n, bo_sum;
  logic [7:0]        mask, shifted, bits;
  logic [SUM_W-1:0]  row_base, pix_index;
  logic [AW-1:0]     addr_full;
  logic              over;
  logic [8:0]        col_step, row_step;
  logic [6:0]        wl_step;
  logic              row_end, glyph_end;

  assign out_ready = !out_valid_r || !out_stall;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  // Datapath for the piece at the cursor
  always_comb begin
    sub       = cursor_col_r[2:0];
    room_byte = 4'd8 - {1'b0, sub};
    room_data = 4'd8 - {1'b0, bit_offset_r};
    use_n     = room_byte;
    if ({3'b000, use_n} > width_left_r) use_n = width_left_r[3:0];
    if (room_data < use_n) use_n = room_data;
    mask      = 8'(8'hff << (4'd8 - use_n));
    shifted   = 8'(head.data << bit_offset_r);
    bits      = (shifted & mask) >> sub;
    row_base  = SUM_W'(cursor_row_r) * SUM_W'(VRAM_ROW_PIXELS);
    pix_index = row_base + SUM_W'(cursor_col_r);
    addr_full = pix_index[SUM_W-1:3];
    over      = 32'(addr_full) >= 32'(LIMIT);
    col_step  = cursor_col_r + 9'(use_n);
    wl_step   = width_left_r - 7'(use_n);
    row_step  = cursor_row_r + 9'd1;
    bo_sum    = {1'b0, bit_offset_r} + use_n;
    row_end   = (wl_step == '0);
    glyph_end = row_end && (row_step == end_row_r);
  end

  always_comb begin
    active_nxt     = active_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    end_row_nxt    = end_row_r;
    left_col_nxt   = left_col_r;
    row_width_nxt  = row_width_r;
    width_left_nxt = width_left_r;
    bit_offset_nxt = bit_offset_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    pop            = 1'b0;

    if (head_valid) begin
      if (head.kind == CMD_START) begin
        pop            = 1'b1;
        left_col_nxt   = head.col;
        cursor_col_nxt = {1'b0, head.col};
        cursor_row_nxt = {1'b0, head.row};
        end_row_nxt    = head.end_row;
        row_width_nxt  = head.width;
        width_left_nxt = head.width;
        bit_offset_nxt = '0;
        active_nxt     = head.live;
      end else if (!active_r) begin
        // drop data with no glyph in progress
        pop = 1'b1;
      end else if (out_ready) begin
        out_valid_nxt      = 1'b1;
        out_nxt            = '0;
        out_nxt.clear_op   = clear_mode_r;
        if (over) begin
          out_nxt.clipped    = 1'b1;
          out_nxt.glyph_done = 1'b1;
          out_nxt.last       = 1'b1;
          active_nxt         = 1'b0;
          pop                = 1'b1;
        end else begin
          out_nxt.fb_address   = FB_ADDR_W'(addr_full);
          out_nxt.pixel_bits   = bits;
          out_nxt.write_enable = 1'b1;
          out_nxt.glyph_done   = glyph_end;
          out_nxt.last         = glyph_end || bo_sum[3];
          pop                  = glyph_end || bo_sum[3];
          bit_offset_nxt       = bo_sum[2:0];
          cursor_col_nxt       = col_step;
          width_left_nxt       = wl_step;
          if (row_end) begin
            cursor_row_nxt = row_step;
            cursor_col_nxt = {1'b0, left_col_r};
            width_left_nxt = row_width_r;
            if (glyph_end) active_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_mode_r <= 1'b0;
      active_r     <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      end_row_r    <= '0;
      left_col_r   <= '0;
      row_width_r  <= '0;
      width_left_r <= '0;
      bit_offset_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_write_en) clear_mode_r <= cfg_clear_mode;
      active_r     <= active_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      end_row_r    <= end_row_nxt;
      left_col_r   <= left_col_nxt;
      row_width_r  <= row_width_nxt;
      width_left_r <= width_left_nxt;
      bit_offset_r <= bit_offset_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/glyph_bit_blit_unit.sv
`default_nettype none

// Channel  | Direction | Handshake           | Beat payload
// ---------+-----------+---------------------+----------------------------------------------
// in_      | sink      | in_valid/in_stall   | command, start_col/row, glyph_width/height, data
// out_     | source    | out_valid/out_stall | fb_address, pixel_bits, flags, last
// cfg_     | sink      | cfg_write_en        | clear_mode
//
// Flow: a start beat is popped as soon as it heads the queue and makes no result;
//   a data beat yields 1 to 8 framebuffer pieces, one per cycle while the output
//   is not stalled, from the single piece datapath in the back part. Data with no glyph in progress is dropped.
// Reset: synchronous rst_n clears the queue, glyph state, clear_mode and the output valid flag.
// Stalls: a two-entry queue parts input from execution; the output register holds
//   a stalled result while the queue keeps accepting input beats until it is full.

module glyph_bit_blit_unit import gbb_pkg::*; #(
  parameter int VRAM_ROW_PIXELS = 256,
  parameter int BUF_ROWS        = 208,
  parameter int BUF_ROW_BYTES   = 32,
  parameter int MAX_GLYPH_SIZE  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic        cfg_clear_mode,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_start_col,
  input  logic [7:0]  in_start_row,
  input  logic [6:0]  in_glyph_width,
  input  logic [6:0]  in_glyph_height,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [12:0] out_fb_address,
  output logic [7:0]  out_pixel_bits,
  output logic        out_write_enable,
  output logic        out_clear_op,
  output logic        out_clipped,
  output logic        out_glyph_done,
  output logic        out_last
);

  logic        q_push, q_full, q_head_valid, q_pop;
  gbb_entry_t  q_entry, q_head;
  gbb_result_t res;

  // Front: classify the beat, clamp sizes, precompute the end row
  gbb_front #(
    .MAX_GLYPH_SIZE(MAX_GLYPH_SIZE)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_start_col   (in_start_col),
    .in_start_row   (in_start_row),
    .in_glyph_width (in_glyph_width),
    .in_glyph_height(in_glyph_height),
    .in_data_byte   (in_data_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  gbb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .head_valid(q_head_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  // Back: walk the glyph cursor, one framebuffer piece per cycle while the output is not stalled
  gbb_back #(
    .VRAM_ROW_PIXELS(VRAM_ROW_PIXELS),
    .BUF_ROWS       (BUF_ROWS),
    .BUF_ROW_BYTES  (BUF_ROW_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_clear_mode(cfg_clear_mode),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .pop           (q_pop),
    .out_stall     (out_stall),
    .res_valid     (out_valid),
    .res           (res)
  );

  assign out_fb_address   = res.fb_address;
  assign out_pixel_bits   = res.pixel_bits;
  assign out_write_enable = res.write_enable;
  assign out_clear_op     = res.clear_op;
  assign out_clipped      = res.clipped;
  assign out_glyph_done   = res.glyph_done;
  assign out_last         = res.last;

endmodule

`default_nettype wire

FILE: rtl/gbb_checker.sv
`default_nettype none

module gbb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [12:0] out_fb_address,
  input logic [7:0]  out_pixel_bits,
  input logic        out_write_enable,
  input logic        out_clipped,
  input logic        out_glyph_done,
  input logic        out_last
);

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fb_address)
      && $stable(out_pixel_bits) && $stable(out_last))
    else $error("stalled result beat changed");

  // Reset drops any pending result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A clipped beat writes nothing and ends both glyph and item
  a_clip_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> !out_write_enable && out_glyph_done && out_last
      && out_fb_address == 13'd0 && out_pixel_bits == 8'd0)
    else $error("malformed clipped beat");

  // Every beat either writes or reports a clip
  a_write_xor_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_write_enable != out_clipped)
    else $error("beat neither writes nor clips");

  // Glyph end also ends the item's beats
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_glyph_done |-> out_last)
    else $error("glyph done without last");

endmodule

bind glyph_bit_blit_unit gbb_checker u_gbb_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top import gbb_pkg::*; ();

  // Geometry of the framebuffer the block is built for
  localparam int ROW_PIXELS   = 256;
  localparam int FB_ROWS      = 208;
  localparam int FB_ROW_BYTES = 32;
  localparam int GLYPH_MAX    = 64;
  localparam int FB_BYTES     = FB_ROWS * FB_ROW_BYTES;

  // Quiet time after the last result before touching clear_mode: covers the
  // two-entry queue plus the pieces of the beat in flight.
  localparam int SETTLE_CYCLES  = 40;
  // Worst honest wait: 8 pieces each held by the longest output stall, plus gaps.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 400;

  // Expected framebuffer pieces and the glyph walker that produces them
  class blit_scoreboard;
    gbb_result_t piece_q[$];
    bit          clear_mode;
    logic [8:0]  cur_col;
    logic [8:0]  cur_row;
    logic [8:0]  stop_row;
    logic [7:0]  left_col;
    logic [6:0]  row_width;
    logic [6:0]  width_left;
    int          bit_pos;
    bit          drawing;
    int          fail_count;
    int          checked_count;
    int          clip_count;

    function new();
      clear_mode    = 1'b0;
      cur_col       = '0;
      cur_row       = '0;
      stop_row      = '0;
      left_col      = '0;
      row_width     = '0;
      width_left    = '0;
      bit_pos       = 0;
      drawing       = 1'b0;
      fail_count    = 0;
      checked_count = 0;
      clip_count    = 0;
    endfunction

    function int size_cap(logic [6:0] v);
      return (int'(v) > GLYPH_MAX) ? GLYPH_MAX : int'(v);
    endfunction

    // Walk one accepted beat; queue the pieces it produces, return their count
    function int note_beat(gbb_cmd_t cmd, logic [7:0] scol, logic [7:0] srow,
                           logic [6:0] gw, logic [6:0] gh, logic [7:0] dbyte);
      gbb_result_t piece[8];
      int          w, h, n, addr, sub, take, mask, bits;
      bit          done;
      if (cmd == CMD_START) begin
        w          = size_cap(gw);
        h          = size_cap(gh);
        left_col   = scol;
        cur_col    = {1'b0, scol};
        cur_row    = {1'b0, srow};
        stop_row   = 9'(int'(srow) + h);
        row_width  = 7'(w);
        width_left = 7'(w);
        bit_pos    = 0;
        drawing    = (w != 0) && (h != 0);
        return 0;
      end
      n = 0;
      while (drawing && bit_pos < 8 && n < 8) begin
        addr = (int'(cur_col) + ROW_PIXELS * int'(cur_row)) / 8;
        sub  = int'(cur_col) & 7;
        done = 1'b0;
        if (addr >= FB_BYTES) begin
          piece[n] = '{fb_address: '0, pixel_bits: '0, write_enable: 1'b0,
                       clear_op: clear_mode, clipped: 1'b1, glyph_done: 1'b1,
                       last: 1'b0};
          n++;
          clip_count++;
          drawing = 1'b0;
        end else begin
          take = 8 - sub;
          if (int'(width_left) < take) take = int'(width_left);
          if (8 - bit_pos < take) take = 8 - bit_pos;
          mask = (255 << (8 - take)) & 255;
          bits = (((int'(dbyte) << bit_pos) & 255) & mask) >> sub;
          bit_pos    += take;
          cur_col    = 9'(int'(cur_col) + take);
          width_left = 7'(int'(width_left) - take);
          if (width_left == 0) begin
            cur_row    = cur_row + 9'd1;
            cur_col    = {1'b0, left_col};
            width_left = row_width;
            if (cur_row == stop_row) begin
              drawing = 1'b0;
              done    = 1'b1;
            end
          end
          piece[n] = '{fb_address: 13'(addr), pixel_bits: 8'(bits), write_enable: 1'b1,
                       clear_op: clear_mode, clipped: 1'b0, glyph_done: done,
                       last: 1'b0};
          n++;
        end
      end
      if (bit_pos >= 8) bit_pos = 0;
      bit_pos &= 7;
      if (n > 0) piece[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) piece_q.push_back(piece[k]);
      return n;
    endfunction

    task report(string msg);
      if (fail_count < 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
    endtask

    task compare_field(string name, logic [12:0] got, logic [12:0] want);
      if (got !== want)
        report($sformatf("%s at piece %0d: got %0h, want %0h",
                         name, checked_count, got, want));
    endtask

    task check_piece(gbb_result_t got);
      gbb_result_t want;
      if (piece_q.size() == 0) begin
        report($sformatf("result beat with nothing pending, addr %0h", got.fb_address));
        return;
      end
      want = piece_q.pop_front();
      compare_field("fb_address", got.fb_address, want.fb_address);
      compare_field("pixel_bits", 13'(got.pixel_bits), 13'(want.pixel_bits));
      compare_field("write_enable", 13'(got.write_enable), 13'(want.write_enable));
      compare_field("clear_op", 13'(got.clear_op), 13'(want.clear_op));
      compare_field("clipped", 13'(got.clipped), 13'(want.clipped));
      compare_field("glyph_done", 13'(got.glyph_done), 13'(want.glyph_done));
      compare_field("last", 13'(got.last), 13'(want.last));
      checked_count++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic        cfg_clear_mode = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [7:0]  in_start_col = '0;
  logic [7:0]  in_start_row = '0;
  logic [6:0]  in_glyph_width = '0;
  logic [6:0]  in_glyph_height = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] out_fb_address;
  logic [7:0]  out_pixel_bits;
  logic        out_write_enable;
  logic        out_clear_op;
  logic        out_clipped;
  logic        out_glyph_done;
  logic        out_last;

  blit_scoreboard sb = new();

  int beats_sent    = 0;
  int items_counted = 0;
  int glyph_count   = 0;
  int idle_cycles   = 0;
  int stall_hold    = 0;
  bit in_quiet      = 1'b0;
  bit out_quiet     = 1'b0;

  glyph_bit_blit_unit #(
    .VRAM_ROW_PIXELS(ROW_PIXELS),
    .BUF_ROWS       (FB_ROWS),
    .BUF_ROW_BYTES  (FB_ROW_BYTES),
    .MAX_GLYPH_SIZE (GLYPH_MAX)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_clear_mode  (cfg_clear_mode),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_start_col    (in_start_col),
    .in_start_row    (in_start_row),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fb_address  (out_fb_address),
    .out_pixel_bits  (out_pixel_bits),
    .out_write_enable(out_write_enable),
    .out_clear_op    (out_clear_op),
    .out_clipped     (out_clipped),
    .out_glyph_done  (out_glyph_done),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure: mostly short stalls, now and then a long one;
  // out_quiet opens stretches where every result is taken at once.
  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (out_quiet || out_stall) begin
      out_stall  <= 1'b0;
      stall_hold = $urandom_range(0, 7);
    end else begin
      r          = $urandom_range(0, 99);
      out_stall  <= 1'b1;
      stall_hold = (r < 85) ? $urandom_range(0, 2) : $urandom_range(3, 30);
    end
  end

  // Check every result beat taken at this edge against the oldest expectation
  always @(posedge clk) begin : result_monitor
    gbb_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.fb_address   = out_fb_address;
      got.pixel_bits   = out_pixel_bits;
      got.write_enable = out_write_enable;
      got.clear_op     = out_clear_op;
      got.clipped      = out_clipped;
      got.glyph_done   = out_glyph_done;
      got.last         = out_last;
      sb.check_piece(got);
    end
  end

  // Abort when neither channel has moved a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat moved for %0d cycles, %0d pieces pending",
                 $realtime, idle_cycles, sb.piece_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Present one input beat, hold it until accepted, then log it for prediction.
  // Valid is only dropped when a gap is taken or in wait_idle, so back-to-back beats keep it high.
  task automatic send_beat(gbb_cmd_t cmd, logic [7:0] scol, logic [7:0] srow,
                           logic [6:0] gw, logic [6:0] gh, logic [7:0] dbyte);
    int gap;
    int made;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_start_col    <= scol;
    in_start_row    <= srow;
    in_glyph_width  <= gw;
    in_glyph_height <= gh;
    in_data_byte    <= dbyte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    made = sb.note_beat(cmd, scol, srow, gw, gh, dbyte);
    beats_sent++;
    // ignored data beats do not advance the stimulus count
    if (cmd == CMD_START || made > 0) items_counted++;
  endtask

  // Unused fields carry random values so every input bit toggles
  task automatic send_start(int scol, int srow, int gw, int gh);
    glyph_count++;
    send_beat(CMD_START, 8'(scol), 8'(srow), 7'(gw), 7'(gh), 8'($urandom));
  endtask

  task automatic send_data(int dbyte);
    send_beat(CMD_DATA, 8'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
              8'(dbyte));
  endtask

  // Drain: wait out every pending piece, then the settle window
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.piece_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called from an idle block, so the new mode applies to later beats only
  task automatic write_clear_mode(bit mode);
    cfg_write_en   <= 1'b1;
    cfg_clear_mode <= mode;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    sb.clear_mode  = mode;
  endtask

  // One glyph: mostly well-formed and on screen, with some oversized, empty,
  // clipped at the bottom, overfed or cut short (abandoned by the next start)
  task automatic random_glyph();
    int pick, w, h, ew, eh, srow, need, nbytes, dbyte;
    pick = $urandom_range(0, 99);
    if (pick < 65)      w = $urandom_range(1, 16);
    else if (pick < 80) w = $urandom_range(17, 64);
    else if (pick < 93) w = $urandom_range(65, 127);
    else                w = 0;
    ew = (w > GLYPH_MAX) ? GLYPH_MAX : w;
    if (ew <= 4)       h = $urandom_range(1, 127);
    else if (ew <= 16) h = $urandom_range(1, 12);
    else               h = $urandom_range(1, 3);
    if ($urandom_range(0, 19) == 0) h = 0;
    eh = (h > GLYPH_MAX) ? GLYPH_MAX : h;
    if ($urandom_range(0, 99) < 85) srow = $urandom_range(0, FB_ROWS - eh);
    else                            srow = $urandom_range(0, 255);

    need = (ew * eh + 7) / 8;
    pick = $urandom_range(0, 99);
    if (need == 0)      nbytes = $urandom_range(1, 2);
    else if (pick < 75) nbytes = need;
    else if (pick < 87) nbytes = need + $urandom_range(1, 3);
    else                nbytes = $urandom_range(0, need - 1);

    in_quiet  = ($urandom_range(0, 4) == 0);
    out_quiet = ($urandom_range(0, 5) == 0);

    // stray data between glyphs
    if ($urandom_range(0, 19) == 0) send_data($urandom_range(0, 255));
    send_start($urandom_range(0, 255), srow, w, h);
    for (int k = 0; k < nbytes; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      dbyte = 8'hff;
      else if (pick == 1) dbyte = 8'h00;
      else                dbyte = $urandom_range(0, 255);
      send_data(dbyte);
    end
  endtask

  initial begin
    int goal;
    bit mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: clear mode first, with the corner cases in a fixed order
    write_clear_mode(1'b1);
    send_data(8'ha5);                 // data with no glyph: ignored
    send_start(0, 0, 8, 1);           // one full byte at address zero
    send_data(8'hff);
    send_start(255, 255, 127, 127);   // all-ones corner, sizes capped, off buffer
    send_data(8'h00);                 // clipped on the first piece
    send_data(8'h55);                 // after the glyph end: ignored
    wait_idle();

    write_clear_mode(1'b0);
    send_start(3, 10, 1, 64);         // one pixel wide: eight pieces per byte
    send_data(8'hff);
    send_data(8'h80);
    send_start(5, 20, 0, 5);          // zero width: stays idle
    send_data(8'hff);
    send_start(5, 20, 5, 0);          // zero height: stays idle
    send_data(8'hff);
    send_start(250, 100, 64, 2);      // row runs past column 255
    send_data(8'hc3);
    send_data(8'h3c);
    send_start(6, FB_ROWS - 1, 3, 2); // abandons the glyph above; clips on row two
    send_data(8'hff);
    send_start(7, 0, 3, 1);           // glyph ends mid byte, rest of byte dropped
    send_data(8'hff);
    wait_idle();

    // Random phases, both modes, each started from an idle block
    for (int phase = 0; phase < 4; phase++) begin
      mode = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom);
      write_clear_mode(mode);
      goal = items_counted + RANDOM_ITEMS / 4;
      while (items_counted < goal) random_glyph();
      in_quiet  = 1'b0;
      out_quiet = 1'b0;
      wait_idle();
    end

    $display("Covered %0d input beats over %0d glyphs, both clear modes, random gaps and stalls;",
             beats_sent, glyph_count);
    $display("checked %0d result pieces, %0d of them buffer-end clips, %0d mismatches.",
             sb.checked_count, sb.clip_count, sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
